>>> rtl/i2a_pkg.sv
`timescale 1ns / 1ps

package i2a_pkg;

  // Field widths
  localparam int VALUE_W = 64;
  localparam int WIDTH_W = 6;
  localparam int CNT_W   = $clog2(VALUE_W);

  // BCD digit store: 20 decimal digits cover any 64-bit magnitude
  localparam int NDIG    = 20;
  localparam int DIGS_W  = 4 * NDIG;
  localparam int ND_W    = $clog2(NDIG + 1);

  // Conversion kinds; bit 1 of the kind selects hexadecimal
  localparam logic [1:0] MODE_SDEC = 2'd0;
  localparam logic [1:0] MODE_UDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam int         HEX_BIT   = 1;

  // Characters
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_A_LOW = 8'h61;
  localparam logic [3:0] DEC_BASE   = 4'd10;

  typedef struct packed {
    logic [1:0]         mode;
    logic [VALUE_W-1:0] value;
    logic               arg_size;
    logic [WIDTH_W-1:0] width;
    logic               zero_pad;
  } req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } rsp_t;

  // Per-number settings handed to the character emitter
  typedef struct packed {
    logic               neg;
    logic [WIDTH_W-1:0] width;
    logic               zero_pad;
  } emit_ctl_t;

  // One digit value (0..15) to its lower-case ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < DEC_BASE) begin
      c = CHAR_ZERO + {4'b0000, d};
    end else begin
      c = CHAR_A_LOW + {4'b0000, d - DEC_BASE};
    end
    return c;
  endfunction

endpackage

>>> rtl/i2a_dabble.sv
`timescale 1ns / 1ps

// Bit-serial binary to BCD converter (shift and add three).
// Decimal takes one cycle per magnitude bit; hex is loaded as nibbles directly.
module i2a_dabble (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              hex,
  input  logic [i2a_pkg::VALUE_W-1:0]       mag,
  output logic                              done,
  output logic [i2a_pkg::DIGS_W-1:0]        digits
);

  logic                         busy;
  logic [i2a_pkg::CNT_W-1:0]    cnt;
  logic [i2a_pkg::VALUE_W-1:0]  bin;
  logic [i2a_pkg::DIGS_W-1:0]   bcd_adj;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < i2a_pkg::NDIG; i++) begin
      if (digits[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = digits[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = digits[4*i +: 4];
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (hex) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == i2a_pkg::CNT_W'(i2a_pkg::VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift path
  always_ff @(posedge clk) begin
    if (start) begin
      if (hex) begin
        digits <= {{(i2a_pkg::DIGS_W - i2a_pkg::VALUE_W){1'b0}}, mag};
      end else begin
        digits <= '0;
      end
      bin <= mag;
    end else if (busy) begin
      digits <= {bcd_adj[i2a_pkg::DIGS_W-2:0], bin[i2a_pkg::VALUE_W-1]};
      bin    <= {bin[i2a_pkg::VALUE_W-2:0], 1'b0};
    end
  end

endmodule

>>> rtl/i2a_emit.sv
`timescale 1ns / 1ps

// Strips leading zero digits one per cycle, then sends sign, pads and
// digits one beat per cycle while rsp_stall is low, through an output register.
module i2a_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [i2a_pkg::DIGS_W-1:0]    digits,
  input  i2a_pkg::emit_ctl_t            ctl,
  output logic                          fin,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output i2a_pkg::rsp_t                 rsp
);

  typedef enum logic [4:0] {
    E_IDLE = 5'b00001,
    E_NORM = 5'b00010,
    E_SIGN = 5'b00100,
    E_PAD  = 5'b01000,
    E_DIG  = 5'b10000
  } emit_state_t;

  emit_state_t                       state;
  logic [i2a_pkg::DIGS_W-1:0]        dig;
  logic [i2a_pkg::ND_W-1:0]          nd;
  logic [i2a_pkg::WIDTH_W-1:0]       pad;
  logic [i2a_pkg::WIDTH_W-1:0]       pad_calc;
  logic [i2a_pkg::WIDTH_W-1:0]       nd_ext;
  logic [3:0]                        top_dig;
  logic                              can_load;

  assign top_dig  = dig[i2a_pkg::DIGS_W-1 -: 4];
  assign can_load = !rsp_valid || !rsp_stall;
  assign nd_ext   = i2a_pkg::WIDTH_W'(nd);
  assign pad_calc = (ctl.width > nd_ext) ? (ctl.width - nd_ext) : '0;

  // Sequencer and output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      rsp_valid <= 1'b0;
      fin       <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (can_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        E_IDLE: begin
          if (start) begin
            state <= E_NORM;
          end
        end
        E_NORM: begin
          if (top_dig == 4'd0 && nd > i2a_pkg::ND_W'(1)) begin
            state <= E_NORM;
          end else if (ctl.neg) begin
            state <= E_SIGN;
          end else if (pad_calc != '0) begin
            state <= E_PAD;
          end else begin
            state <= E_DIG;
          end
        end
        E_SIGN: begin
          if (can_load) begin
            rsp_valid <= 1'b1;
            state     <= (pad != '0) ? E_PAD : E_DIG;
          end
        end
        E_PAD: begin
          if (can_load) begin
            rsp_valid <= 1'b1;
            if (pad == i2a_pkg::WIDTH_W'(1)) begin
              state <= E_DIG;
            end
          end
        end
        E_DIG: begin
          if (can_load) begin
            rsp_valid <= 1'b1;
            if (nd == i2a_pkg::ND_W'(1)) begin
              state <= E_IDLE;
              fin   <= 1'b1;
            end
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  // Digit store, counts and beat payload
  always_ff @(posedge clk) begin
    case (state)
      E_IDLE: begin
        if (start) begin
          dig <= digits;
          nd  <= i2a_pkg::ND_W'(i2a_pkg::NDIG);
        end
      end
      E_NORM: begin
        if (top_dig == 4'd0 && nd > i2a_pkg::ND_W'(1)) begin
          dig <= {dig[i2a_pkg::DIGS_W-5:0], 4'd0};
          nd  <= nd - 1'b1;
        end else begin
          pad <= pad_calc;
        end
      end
      E_SIGN: begin
        if (can_load) begin
          rsp.out_char <= i2a_pkg::CHAR_MINUS;
          rsp.last     <= 1'b0;
        end
      end
      E_PAD: begin
        if (can_load) begin
          rsp.out_char <= ctl.zero_pad ? i2a_pkg::CHAR_ZERO : i2a_pkg::CHAR_SPACE;
          rsp.last     <= 1'b0;
          pad          <= pad - 1'b1;
        end
      end
      E_DIG: begin
        if (can_load) begin
          rsp.out_char <= i2a_pkg::digit_char(top_dig);
          rsp.last     <= (nd == i2a_pkg::ND_W'(1));
          dig          <= {dig[i2a_pkg::DIGS_W-5:0], 4'd0};
          nd           <= nd - 1'b1;
        end
      end
      default: begin
        pad <= pad;
      end
    endcase
  end

endmodule

>>> rtl/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps

// Formats one integer request as ASCII characters, most significant first:
// an optional '-', then pad characters up to the requested digit width, then
// the digits. One request is handled at a time. After the request beat, a
// decimal conversion runs bit-serially through the BCD converter (hex is
// loaded as nibbles directly), then the emitter loads the digit store, drops
// leading zero digits and sets up the pad count, then sends one character
// beat per cycle while rsp_stall is low. A request yields up to 64
// characters; the next request beat can be taken once fin has pulsed and the
// busy state has returned to idle after the last character is loaded into
// the output register.
module integer_to_ascii_formatter (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  i2a_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output i2a_pkg::rsp_t   rsp
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } top_state_t;

  top_state_t                        state;
  logic                              accept;
  logic                              hex;
  logic                              neg;
  logic [i2a_pkg::VALUE_W-1:0]       mag;
  logic [31:0]                       low;
  logic                              conv_done;
  logic [i2a_pkg::DIGS_W-1:0]        digits;
  logic                              fin;
  i2a_pkg::emit_ctl_t                ctl;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  // Argument size, sign and magnitude
  assign hex = req.mode[i2a_pkg::HEX_BIT];
  assign low = req.value[31:0];
  always_comb begin
    if (req.arg_size) begin
      neg = (req.mode == i2a_pkg::MODE_SDEC) && req.value[i2a_pkg::VALUE_W-1];
      mag = neg ? (~req.value + 1'b1) : req.value;
    end else begin
      neg = (req.mode == i2a_pkg::MODE_SDEC) && low[31];
      mag = {32'd0, neg ? (~low + 1'b1) : low};
    end
  end

  // Busy from request beat until fin reports the last character loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (fin) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl.neg      <= neg;
      ctl.width    <= req.width;
      ctl.zero_pad <= req.zero_pad;
    end
  end

  i2a_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .hex    (hex),
    .mag    (mag),
    .done   (conv_done),
    .digits (digits)
  );

  i2a_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (conv_done),
    .digits    (digits),
    .ctl       (ctl),
    .fin       (fin),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
